// ===== design/hmac_sha1_stream_top_assert.svh =====
// assertion macros for the hmac sha1 stream block
// used by hmac_sha1_stream_top only
`ifndef HMAC_SHA1_STREAM_TOP_ASSERT_SVH
`define HMAC_SHA1_STREAM_TOP_ASSERT_SVH

// implication checked on every clock edge out of reset
`define HS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/hs1_pkg.sv =====
// package for the hmac sha1 stream block: types, constants, round helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hs1_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int DIGEST_BYTES = 20;
    localparam int KEY_WORDS    = 8;

    localparam logic [31:0] IPAD_FILL = 32'h36363636;
    localparam logic [31:0] OPAD_FILL = 32'h5c5c5c5c;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // outer block length field: 84 bytes in bits
    localparam logic [31:0] OUTER_LEN_BITS = 32'((BLOCK_BYTES + DIGEST_BYTES) * 8);

    // source of the 16 words for one compression
    typedef enum logic [1:0] {
        SRC_BUF   = 2'd0,
        SRC_IPAD  = 2'd1,
        SRC_OPAD  = 2'd2,
        SRC_OUTER = 2'd3
    } src_t;

    // which chaining state a compression updates
    typedef enum logic {
        TGT_INNER = 1'b0,
        TGT_OUTER = 1'b1
    } tgt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IPAD,
        ST_OPAD,
        ST_BYTE,
        ST_MSGBLK,
        ST_PAD,
        ST_FIN1,
        ST_FIN2,
        ST_OUTER,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        start;     // begin a compression
        src_t        src;
        tgt_t        tgt;
        logic        load_iv;   // load iv into chaining state before compressing
        logic        put_byte;  // write data byte at current position
        logic        put_pad;   // write 0x80 and clear rest, optionally length
        logic        put_len;   // write bit length into words 14 and 15
        logic        clr_buf;   // clear words 0 to 13, write bit length into words 14 and 15
        logic        clr_count;
        logic        emit_load; // load output word index 0
        logic        emit_next;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic busy;       // compression running
        logic pos_end;    // current byte position is 63 before the write
        logic pad_spill;  // padding needs an extra block
        logic emit_last;  // output index at word 4
    } stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        case (i)
            3'd0:    iv_word = IV0;
            3'd1:    iv_word = IV1;
            3'd2:    iv_word = IV2;
            3'd3:    iv_word = IV3;
            default: iv_word = IV4;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== design/hs1_ctrl.sv =====
// hmac sha1 sequencer: opens messages, schedules compressions, emits digest
// depends on hs1_pkg
`timescale 1ns / 1ps
`default_nettype none
module hs1_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          has_byte,
    input  wire logic          is_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire hs1_pkg::stat_t stat,
    output hs1_pkg::cmd_t      cmd
);

    hs1_pkg::state_t state_reg, state_next;
    logic open_reg, open_next;
    logic last_reg, last_next;
    logic byte_reg, byte_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hs1_pkg::ST_IDLE;
            open_reg  <= 1'b0;
            last_reg  <= 1'b0;
            byte_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            last_reg  <= last_next;
            byte_reg  <= byte_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        last_next  = last_reg;
        byte_next  = byte_reg;
        cmd        = '0;
        cmd.src    = hs1_pkg::SRC_BUF;
        cmd.tgt    = hs1_pkg::TGT_INNER;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            hs1_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = is_last;
                    byte_next = has_byte;
                    if (!open_reg)
                    begin
                        open_next     = 1'b1;
                        cmd.clr_count = 1'b1;
                        cmd.start     = 1'b1;
                        cmd.load_iv   = 1'b1;
                        cmd.src       = hs1_pkg::SRC_IPAD;
                        cmd.tgt       = hs1_pkg::TGT_INNER;
                        state_next    = hs1_pkg::ST_IPAD;
                    end
                    else
                        state_next = hs1_pkg::ST_BYTE;
                end
            end
            hs1_pkg::ST_IPAD:
            begin
                if (!stat.busy)
                begin
                    cmd.start   = 1'b1;
                    cmd.load_iv = 1'b1;
                    cmd.src     = hs1_pkg::SRC_OPAD;
                    cmd.tgt     = hs1_pkg::TGT_OUTER;
                    state_next  = hs1_pkg::ST_OPAD;
                end
            end
            hs1_pkg::ST_OPAD:
            begin
                if (!stat.busy)
                    state_next = hs1_pkg::ST_BYTE;
            end
            hs1_pkg::ST_BYTE:
            begin
                if (byte_reg)
                begin
                    cmd.put_byte = 1'b1;
                    if (stat.pos_end)
                    begin
                        cmd.start  = 1'b1;
                        state_next = hs1_pkg::ST_MSGBLK;
                    end
                    else
                        state_next = last_reg ? hs1_pkg::ST_PAD : hs1_pkg::ST_IDLE;
                end
                else
                    state_next = last_reg ? hs1_pkg::ST_PAD : hs1_pkg::ST_IDLE;
            end
            hs1_pkg::ST_MSGBLK:
            begin
                if (!stat.busy)
                    state_next = last_reg ? hs1_pkg::ST_PAD : hs1_pkg::ST_IDLE;
            end
            hs1_pkg::ST_PAD:
            begin
                cmd.put_pad = 1'b1;
                cmd.start   = 1'b1;
                if (stat.pad_spill)
                    state_next = hs1_pkg::ST_FIN1;
                else
                begin
                    cmd.put_len = 1'b1;
                    state_next  = hs1_pkg::ST_FIN2;
                end
            end
            hs1_pkg::ST_FIN1:
            begin
                if (!stat.busy)
                begin
                    cmd.clr_buf = 1'b1;
                    cmd.put_len = 1'b1;
                    cmd.start   = 1'b1;
                    state_next  = hs1_pkg::ST_FIN2;
                end
            end
            hs1_pkg::ST_FIN2:
            begin
                if (!stat.busy)
                begin
                    cmd.start  = 1'b1;
                    cmd.src    = hs1_pkg::SRC_OUTER;
                    cmd.tgt    = hs1_pkg::TGT_OUTER;
                    state_next = hs1_pkg::ST_OUTER;
                end
            end
            hs1_pkg::ST_OUTER:
            begin
                if (!stat.busy)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = hs1_pkg::ST_EMIT;
                end
            end
            hs1_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    if (stat.emit_last)
                    begin
                        open_next     = 1'b0;
                        cmd.clr_count = 1'b1;
                        state_next    = hs1_pkg::ST_IDLE;
                    end
                end
            end
            default:
                state_next = hs1_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/hs1_datapath.sv =====
// hmac sha1 datapath: key registers, block buffer, byte counter, sha1 round unit
// depends on hs1_pkg
`timescale 1ns / 1ps
`default_nettype none
module hs1_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          key_we,
    input  wire logic [2:0]    key_idx,
    input  wire logic [63:0]   key_wdata,
    output logic [63:0]        key_rdata,
    input  wire logic          in_take,
    input  wire logic [7:0]    data_byte,
    input  wire hs1_pkg::cmd_t cmd,
    output hs1_pkg::stat_t     stat,
    output logic [31:0]        digest_word,
    output logic               last_word
);

    logic [63:0] key_reg [hs1_pkg::KEY_WORDS];
    logic [31:0] buf_reg [16];
    logic [31:0] w_reg   [16];
    logic [31:0] ih_reg  [5];
    logic [31:0] oh_reg  [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] count_reg;
    logic [7:0]  byte_reg;
    logic [6:0]  round_reg;
    logic        busy_reg;
    hs1_pkg::src_t src_reg;
    hs1_pkg::tgt_t tgt_reg;
    logic [2:0]  oidx_reg;

    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [4:0]  sh;
    logic [63:0] bits;
    logic [31:0] wsrc, wnew, f, k, tmp;
    logic [31:0] h0, h1, h2, h3, h4;
    logic [31:0] keyw;
    logic [31:0] fill;

    assign pos  = count_reg[5:0];
    assign wi   = pos[5:2];
    assign sh   = {~pos[1:0], 3'b000};
    assign bits = {count_reg[60:0], 3'b000};

    assign key_rdata     = key_reg[key_idx];
    assign stat.busy     = busy_reg;
    assign stat.pos_end  = (pos == 6'(hs1_pkg::BLOCK_BYTES - 1));
    assign stat.pad_spill = (pos > 6'(hs1_pkg::BLOCK_BYTES - 9));
    assign stat.emit_last = (oidx_reg == 3'd4);
    assign digest_word   = oh_reg[oidx_reg];
    assign last_word     = (oidx_reg == 3'd4);

    // chaining state the round unit starts from
    always_comb
    begin
        if (tgt_reg == hs1_pkg::TGT_INNER)
        begin
            h0 = ih_reg[0]; h1 = ih_reg[1]; h2 = ih_reg[2]; h3 = ih_reg[3]; h4 = ih_reg[4];
        end
        else
        begin
            h0 = oh_reg[0]; h1 = oh_reg[1]; h2 = oh_reg[2]; h3 = oh_reg[3]; h4 = oh_reg[4];
        end
    end

    // message word for rounds 0 to 15, from the selected source
    always_comb
    begin
        keyw = round_reg[0] ? key_reg[round_reg[3:1]][31:0] : key_reg[round_reg[3:1]][63:32];
        fill = (src_reg == hs1_pkg::SRC_IPAD) ? hs1_pkg::IPAD_FILL : hs1_pkg::OPAD_FILL;
        case (src_reg)
            hs1_pkg::SRC_BUF:  wsrc = buf_reg[round_reg[3:0]];
            hs1_pkg::SRC_IPAD: wsrc = keyw ^ fill;
            hs1_pkg::SRC_OPAD: wsrc = keyw ^ fill;
            hs1_pkg::SRC_OUTER:
            begin
                if (round_reg < 7'd5)
                    wsrc = ih_reg[round_reg[2:0]];
                else if (round_reg == 7'd5)
                    wsrc = 32'h80000000;
                else if (round_reg == 7'd15)
                    wsrc = hs1_pkg::OUTER_LEN_BITS;
                else
                    wsrc = '0;
            end
            default: wsrc = '0;
        endcase
    end

    // one sha1 round
    always_comb
    begin
        if (round_reg < 7'd16)
            wnew = wsrc;
        else
            wnew = hs1_pkg::rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        if (round_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = 32'h5A827999;
        end
        else if (round_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg; k = 32'h6ED9EBA1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg; k = 32'hCA62C1D6;
        end
        tmp = hs1_pkg::rotl(a_reg, 5) + f + e_reg + k + wnew;
    end

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hs1_pkg::KEY_WORDS; i++)
                key_reg[i] <= '0;
        end
        else if (key_we)
            key_reg[key_idx] <= key_wdata;
    end

    // captured input byte
    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= data_byte;
    end

    // block buffer writes
    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
            buf_reg[wi] <= (buf_reg[wi] & ~(32'hFF << sh)) | ({24'd0, byte_reg} << sh);
        else if (cmd.put_pad)
        begin
            buf_reg[wi] <= (buf_reg[wi] & ~(32'hFFFFFFFF >> (5'd24 - sh)))
                           | (32'h80 << sh);
            for (int i = 0; i < 16; i++)
                if (4'(i) > wi && !(cmd.put_len && i >= 14))
                    buf_reg[i] <= '0;
            if (cmd.put_len)
            begin
                buf_reg[14] <= bits[63:32];
                buf_reg[15] <= bits[31:0];
            end
        end
        else if (cmd.clr_buf)
        begin
            for (int i = 0; i < 14; i++)
                buf_reg[i] <= '0;
            buf_reg[14] <= bits[63:32];
            buf_reg[15] <= bits[31:0];
        end
    end

    // byte counter and output index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            oidx_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_count)
                count_reg <= '0;
            else if (cmd.put_byte)
                count_reg <= count_reg + 64'd1;
            if (cmd.emit_load)
                oidx_reg <= '0;
            else if (cmd.emit_next && oidx_reg != 3'd4)
                oidx_reg <= oidx_reg + 3'd1;
        end
    end

    // round sequencer and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            src_reg   <= hs1_pkg::SRC_BUF;
            tgt_reg   <= hs1_pkg::TGT_INNER;
            for (int i = 0; i < 5; i++)
            begin
                ih_reg[i] <= hs1_pkg::iv_word(3'(i));
                oh_reg[i] <= hs1_pkg::iv_word(3'(i));
            end
        end
        else if (cmd.start)
        begin
            busy_reg  <= 1'b1;
            round_reg <= '0;
            src_reg   <= cmd.src;
            tgt_reg   <= cmd.tgt;
            if (cmd.load_iv)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    if (cmd.tgt == hs1_pkg::TGT_INNER)
                        ih_reg[i] <= hs1_pkg::iv_word(3'(i));
                    else
                        oh_reg[i] <= hs1_pkg::iv_word(3'(i));
                end
            end
        end
        else if (busy_reg)
        begin
            if (round_reg == 7'd80)
            begin
                busy_reg <= 1'b0;
                if (tgt_reg == hs1_pkg::TGT_INNER)
                begin
                    ih_reg[0] <= h0 + a_reg; ih_reg[1] <= h1 + b_reg;
                    ih_reg[2] <= h2 + c_reg; ih_reg[3] <= h3 + d_reg;
                    ih_reg[4] <= h4 + e_reg;
                end
                else
                begin
                    oh_reg[0] <= h0 + a_reg; oh_reg[1] <= h1 + b_reg;
                    oh_reg[2] <= h2 + c_reg; oh_reg[3] <= h3 + d_reg;
                    oh_reg[4] <= h4 + e_reg;
                end
            end
            else
                round_reg <= round_reg + 7'd1;
        end
    end

    // working variables and rolling schedule
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= cmd.load_iv ? hs1_pkg::IV0 : ((cmd.tgt == hs1_pkg::TGT_INNER) ? ih_reg[0] : oh_reg[0]);
            b_reg <= cmd.load_iv ? hs1_pkg::IV1 : ((cmd.tgt == hs1_pkg::TGT_INNER) ? ih_reg[1] : oh_reg[1]);
            c_reg <= cmd.load_iv ? hs1_pkg::IV2 : ((cmd.tgt == hs1_pkg::TGT_INNER) ? ih_reg[2] : oh_reg[2]);
            d_reg <= cmd.load_iv ? hs1_pkg::IV3 : ((cmd.tgt == hs1_pkg::TGT_INNER) ? ih_reg[3] : oh_reg[3]);
            e_reg <= cmd.load_iv ? hs1_pkg::IV4 : ((cmd.tgt == hs1_pkg::TGT_INNER) ? ih_reg[4] : oh_reg[4]);
        end
        else if (busy_reg && round_reg != 7'd80)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= hs1_pkg::rotl(b_reg, 30);
            b_reg <= a_reg;
            a_reg <= tmp;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
        end
    end

endmodule
`default_nettype wire

// ===== design/hmac_sha1_stream_top.sv =====
// hmac sha1 stream engine: top level with apb key port and valid/ready channels
// depends on hs1_pkg, hs1_ctrl, hs1_datapath, hmac_sha1_stream_top_assert.svh
//
// usage:
//  - key: eight 64-bit words at byte addresses 8*i on the apb port, read at the
//    start of each message; write only while idle
//  - input beats carry data_byte, has_byte and is_last; one beat is taken at a
//    time, then in_ready drops while it is processed
//  - a beat with a byte writes it into the block buffer; the 64th byte of a block
//    adds one sha1 compression (one round per cycle in the shared round unit)
//  - the first beat of a message first runs the two key pad compressions
//  - the last beat adds one or two inner compressions and the outer one,
//    then five output beats, word 0 first, last_word high on the fifth
//  - when the receiver stalls, the digest word holds and no input is taken
//  - reset clears the key, the counters and the controller and loads the iv into
//    the chaining state; nothing else needs clearing
`timescale 1ns / 1ps
`default_nettype none
`include "hmac_sha1_stream_top_assert.svh"
module hmac_sha1_stream_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic             last_word
);

    hs1_pkg::cmd_t  cmd;
    hs1_pkg::stat_t stat;
    logic           key_we;
    logic [63:0]    key_rdata;

    // apb write decode
    assign pready = 1'b1;
    assign key_we = psel && penable && pwrite;
    assign prdata = key_rdata;

    hs1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hs1_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_we      (key_we),
        .key_idx     (paddr[5:3]),
        .key_wdata   (pwdata),
        .key_rdata   (key_rdata),
        .in_take     (in_valid && in_ready),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word),
        .last_word   (last_word)
    );

    // input and output never both open
    `HS_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
    // a compression start never lands on a running one
    `HS_ASSERT_IMP(a_start_idle, cmd.start, !stat.busy)
    // final word taken closes the output
    `HS_ASSERT_NEXT(a_last_closes, out_valid && out_ready && last_word, !out_valid)

endmodule
`default_nettype wire
